// ===== hw/rtl/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg: shared types and constants for the sorted message queue
// Entry layout, command codes, status codes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package smq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ROUTE_W  = 10;
    localparam int TICK_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } t_status;

    typedef struct packed {
        logic [ROUTE_W-1:0] route;
        logic [TICK_W-1:0]  depart;
        logic [TICK_W-1:0]  arrival;
    } t_entry;

    // Broadcast to every cell in the commit cycle
    typedef struct packed {
        logic   do_insert;
        logic   do_remove;
        t_entry item;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/smq_cell.sv =====
// ----------------------------------------------------------------------------
// smq_cell: one slot of the sorted queue chain
// Holds one entry; on insert it keeps, takes the new entry or takes the left
// neighbor; on remove it keeps or takes the right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module smq_cell (
    input  wire                 i_clk,
    input  smq_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_occupied,    // slot index below fill count
    input  wire                 i_from_pos,    // slot index at or past remove position
    input  wire                 i_prev_keep,   // left neighbor stays put on insert
    input  smq_pkg::t_entry     i_prev_entry,
    input  smq_pkg::t_entry     i_next_entry,
    output logic                o_keep,
    output smq_pkg::t_entry     o_entry
);

    smq_pkg::t_entry r_entry;
    smq_pkg::t_entry n_entry;

    // Held entry sorts at or before the new one: it stays (ties keep order)
    assign o_keep  = i_occupied && (r_entry.arrival <= i_ctrl.item.arrival);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.do_insert && !o_keep) begin
            n_entry = i_prev_keep ? i_ctrl.item : i_prev_entry;
        end else if (i_ctrl.do_remove && i_from_pos) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_message_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_message_queue_core: arrival-ordered message queue
// Chain of entry cells kept in ascending arrival order, with insert and
// remove-at-position requests and one result per request.
// ----------------------------------------------------------------------------
// Each request is registered at acceptance and applied to all QUEUE_DEPTH cells
// once the result register is free or being drained; every cell then compares
// its arrival with the new key and shifts by one slot toward or away from the
// head. The result is then held in an output register; while it waits, the
// next request is accepted but not applied until the result is taken, and no
// other is accepted until then. Insert places the entry after all entries of
// equal or smaller arrival. Insert into a full queue returns status full and
// changes nothing; remove at a position at or past the count returns status
// absent and changes nothing. Head fields read zero when the queue is empty;
// taken fields read zero unless an entry was removed. No clearing pass is
// needed after reset: only slots below the count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_message_queue_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // request channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_cmd,
    input  wire [smq_pkg::ROUTE_W-1:0]   i_route_in,
    input  wire [smq_pkg::TICK_W-1:0]    i_depart_in,
    input  wire [smq_pkg::TICK_W-1:0]    i_arrival_in,
    input  wire [smq_pkg::POS_W-1:0]     i_position,
    // result channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [smq_pkg::STATUS_W-1:0] o_status,
    output logic [smq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                         o_head_valid,
    output logic [smq_pkg::ROUTE_W-1:0]  o_head_route,
    output logic [smq_pkg::TICK_W-1:0]   o_head_depart,
    output logic [smq_pkg::TICK_W-1:0]   o_head_arrival,
    output logic [smq_pkg::ROUTE_W-1:0]  o_taken_route,
    output logic [smq_pkg::TICK_W-1:0]   o_taken_depart,
    output logic [smq_pkg::TICK_W-1:0]   o_taken_arrival
);

    localparam int DEPTH = smq_pkg::QUEUE_DEPTH;
    localparam int CNT_W = smq_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // captured request
    smq_pkg::t_cmd            r_cmd;
    smq_pkg::t_entry          r_item;
    logic [smq_pkg::POS_W-1:0] r_pos;

    // queue fill count
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // result register
    logic                 r_out_valid;
    smq_pkg::t_status     r_status;
    smq_pkg::t_entry      r_taken;
    smq_pkg::t_status     n_status;

    smq_pkg::t_cell_ctrl  cell_ctrl;
    smq_pkg::t_entry      cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_keep;
    logic [DEPTH-1:0]     cell_occ;
    logic [DEPTH-1:0]     cell_from_pos;
    logic [DEPTH-1:0]     cell_at_pos;
    smq_pkg::t_entry      taken_sel;

    logic accept;
    logic commit;
    logic is_full;
    logic pos_absent;

    assign accept = i_valid && !o_stall;
    // apply only when the result register is free or being drained
    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    assign is_full    = (32'(r_count) >= 32'(DEPTH));
    assign pos_absent = (32'(r_pos) >= 32'(r_count));

    always_comb begin
        cell_ctrl.item      = r_item;
        cell_ctrl.do_insert = commit && (r_cmd == smq_pkg::CMD_INSERT) && !is_full;
        cell_ctrl.do_remove = commit && (r_cmd == smq_pkg::CMD_REMOVE) && !pos_absent;
    end

    // per-slot position flags
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_occ[k]      = (32'(k) < 32'(r_count));
            cell_from_pos[k] = (32'(k) >= 32'(r_pos));
            cell_at_pos[k]   = (32'(k) == 32'(r_pos));
        end
    end

    // the chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        smq_pkg::t_entry prev_entry;
        smq_pkg::t_entry next_entry;
        logic            prev_keep;

        if (g == 0) begin : g_first
            assign prev_entry = r_item;
            assign prev_keep  = 1'b1;
        end else begin : g_mid
            assign prev_entry = cell_entry[g-1];
            assign prev_keep  = cell_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_entry = cell_entry[g];
        end else begin : g_inner
            assign next_entry = cell_entry[g+1];
        end

        smq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_occupied   (cell_occ[g]),
            .i_from_pos   (cell_from_pos[g]),
            .i_prev_keep  (prev_keep),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_keep       (cell_keep[g]),
            .o_entry      (cell_entry[g])
        );
    end

    // one-hot pick of the entry at the remove position
    always_comb begin
        taken_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (cell_at_pos[k]) begin
                taken_sel = taken_sel | cell_entry[k];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = smq_pkg::ST_DONE;
        if (r_cmd == smq_pkg::CMD_INSERT) begin
            if (is_full) begin
                n_status = smq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (pos_absent) begin
                n_status = smq_pkg::ST_ABSENT;
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd          <= smq_pkg::t_cmd'(i_cmd);
            r_item.route   <= i_route_in;
            r_item.depart  <= i_depart_in;
            r_item.arrival <= i_arrival_in;
            r_pos          <= i_position;
        end
        if (commit) begin
            r_status <= n_status;
            if (cell_ctrl.do_remove) begin
                r_taken <= taken_sel;
            end else begin
                r_taken <= '0;
            end
        end
    end

    // head reads the live chain; it only moves on commit, which also
    // replaces the result, so it is stable while the result is stalled
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_count   = smq_pkg::COUNT_W'(r_count);
    assign o_head_valid    = (r_count != '0);
    assign o_head_route    = o_head_valid ? cell_entry[0].route   : '0;
    assign o_head_depart   = o_head_valid ? cell_entry[0].depart  : '0;
    assign o_head_arrival  = o_head_valid ? cell_entry[0].arrival : '0;
    assign o_taken_route   = r_taken.route;
    assign o_taken_depart  = r_taken.depart;
    assign o_taken_arrival = r_taken.arrival;

endmodule

`default_nettype wire

// ===== tb/tb_sorted_message_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_message_queue_core: self-checking bench for the sorted queue
// Drives insert and remove requests with random idle gaps and result stalls.
// A shadow queue in the bench predicts every result, which is then compared
// field by field with what the block returns.
// ----------------------------------------------------------------------------

module tb_sorted_message_queue_core;

    import smq_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int CYCLE_LIMIT = 800_000;
    localparam int TAIL_CYCLES = 10;

    // One request as queued for the driver. hold makes the driver wait until
    // every outstanding result has come back before presenting it.
    typedef struct packed {
        logic              hold;
        t_cmd              cmd;
        t_entry            item;
        logic [POS_W-1:0]  position;
    } t_queue_request;

    typedef struct packed {
        t_status             status;
        logic [COUNT_W-1:0]  count;
        logic                head_valid;
        t_entry              head;
        t_entry              taken;
    } t_queue_result;

    // ------------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_stall;
    logic                 i_cmd         = 1'b0;
    logic [ROUTE_W-1:0]   i_route_in    = '0;
    logic [TICK_W-1:0]    i_depart_in   = '0;
    logic [TICK_W-1:0]    i_arrival_in  = '0;
    logic [POS_W-1:0]     i_position    = '0;
    logic                 o_valid;
    logic                 i_stall       = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [COUNT_W-1:0]   o_entry_count;
    logic                 o_head_valid;
    logic [ROUTE_W-1:0]   o_head_route;
    logic [TICK_W-1:0]    o_head_depart;
    logic [TICK_W-1:0]    o_head_arrival;
    logic [ROUTE_W-1:0]   o_taken_route;
    logic [TICK_W-1:0]    o_taken_depart;
    logic [TICK_W-1:0]    o_taken_arrival;

    sorted_message_queue_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_route_in      (i_route_in),
        .i_depart_in     (i_depart_in),
        .i_arrival_in    (i_arrival_in),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_head_valid    (o_head_valid),
        .o_head_route    (o_head_route),
        .o_head_depart   (o_head_depart),
        .o_head_arrival  (o_head_arrival),
        .o_taken_route   (o_taken_route),
        .o_taken_depart  (o_taken_depart),
        .o_taken_arrival (o_taken_arrival)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_queue_request  request_backlog[$];   // built up front, drained by driver
    t_queue_result   due_results[$];       // predicted, oldest first
    t_entry          shadow_entries[$];    // predicted queue contents, head at 0

    t_queue_request  live_request;
    logic            live_taken;

    int  requests_sent  = 0;   // NBA-updated so other blocks read stable values
    int  results_taken  = 0;
    int  errors         = 0;
    int  cycle_count    = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  quiet_send     = 1'b0;
    bit  quiet_recv     = 1'b0;

    // generator bookkeeping: tracks the fill level so removes can aim at
    // positions that are actually held
    int  gen_count      = 0;
    int  gen_made       = 0;
    bit  hold_next      = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction: apply one request to the shadow queue
    // ------------------------------------------------------------------------
    function automatic t_queue_result queue_outcome(t_queue_request rq);
        t_queue_result r;
        int            slot;
        r = '0;
        r.status = ST_DONE;
        if (rq.cmd == CMD_INSERT) begin
            if (shadow_entries.size() >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // land after every entry with an equal or smaller key
                slot = 0;
                while (slot < shadow_entries.size()
                       && shadow_entries[slot].arrival <= rq.item.arrival)
                    slot++;
                shadow_entries.insert(slot, rq.item);
            end
        end else begin
            if (rq.position >= shadow_entries.size()) begin
                r.status = ST_ABSENT;
            end else begin
                r.taken = shadow_entries[rq.position];
                shadow_entries.delete(rq.position);
            end
        end
        r.count = COUNT_W'(shadow_entries.size());
        if (shadow_entries.size() > 0) begin
            r.head_valid = 1'b1;
            r.head       = shadow_entries[0];
        end
        return r;
    endfunction

    // Mostly short gaps, some medium, a few long; none during quiet stretches
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------
    task automatic add_request(t_cmd cmd, logic [ROUTE_W-1:0] route,
                               logic [TICK_W-1:0] depart, logic [TICK_W-1:0] arrival,
                               logic [POS_W-1:0] pos);
        t_queue_request rq;
        rq.hold         = hold_next;
        rq.cmd          = cmd;
        rq.item.route   = route;
        rq.item.depart  = depart;
        rq.item.arrival = arrival;
        rq.position     = pos;
        hold_next       = 1'b0;
        request_backlog.push_back(rq);
        gen_made++;
        if (cmd == CMD_INSERT) begin
            if (gen_count < QUEUE_DEPTH)
                gen_count++;
        end else if (pos < gen_count) begin
            gen_count--;
        end
    endtask

    // Keys favor a narrow range so equal arrivals are common
    function automatic logic [TICK_W-1:0] pick_tick();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return TICK_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic logic [ROUTE_W-1:0] pick_route();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return ROUTE_W'($urandom_range(0, 1023));
    endfunction

    task automatic add_random_insert();
        add_request(CMD_INSERT, pick_route(), pick_tick(), pick_tick(),
                    POS_W'($urandom_range(0, 63)));
    endtask

    // pos < 0 picks a held position when there is one
    task automatic add_random_remove(int pos);
        int p;
        if (pos >= 0)
            p = pos;
        else if (gen_count > 0)
            p = $urandom_range(0, gen_count - 1);
        else
            p = $urandom_range(0, 63);
        add_request(CMD_REMOVE, pick_route(), $urandom, $urandom, POS_W'(p));
    endtask

    initial begin
        int r;

        // Directed: empty remove, key extremes, ties at head, middle and
        // tail, out-of-range removes, removes at last/middle/head, drain.
        add_random_remove(0);
        add_request(CMD_INSERT, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        add_request(CMD_INSERT, 10'h000, 32'h0000_0000, 32'h0000_0000, 6'd63);
        add_request(CMD_INSERT, 10'd5,   32'h0000_0001, 32'h0000_0000, 6'd0);
        add_request(CMD_INSERT, 10'd6,   32'h5555_5555, 32'hFFFF_FFFF, 6'd0);
        add_request(CMD_INSERT, 10'h2AA, 32'hAAAA_AAAA, 32'h8000_0000, 6'd0);
        add_request(CMD_INSERT, 10'h155, 32'h1234_5678, 32'h7FFF_FFFF, 6'd0);
        add_random_remove(63);
        add_random_remove(6);
        add_random_remove(5);
        add_random_remove(2);
        add_random_remove(0);
        add_request(CMD_INSERT, 10'h3FF, 32'h0000_0000, 32'h8000_0000, 6'd0);
        add_random_remove(1);
        repeat (3) add_random_remove(0);
        add_random_remove(0);
        add_random_insert();

        // first forced drain before the random part
        hold_next = 1'b1;

        while (gen_made < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            case (r)
                0: begin
                    // fill to the top, then knock on a full queue
                    while (gen_count < QUEUE_DEPTH)
                        add_random_insert();
                    repeat ($urandom_range(1, 3)) add_random_insert();
                    if ($urandom_range(0, 1) == 1)
                        add_random_remove(63);
                end
                1: begin
                    // empty it out, then one remove on the empty queue
                    while (gen_count > 0)
                        add_random_remove($urandom_range(0, 1) == 1 ? 0 : -1);
                    add_random_remove($urandom_range(0, 63));
                end
                2: hold_next = 1'b1;
                default: begin
                    repeat ($urandom_range(4, 30)) begin
                        r = $urandom_range(0, 99);
                        if (r < 50)
                            add_random_insert();
                        else if (r < 92)
                            add_random_remove(-1);
                        else
                            add_random_remove($urandom_range(0, 63));
                    end
                end
            endcase
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every request accepted, every result back, then a short tail
        while (request_backlog.size() > 0 || i_valid)
            @(posedge i_clk);
        while (results_taken != requests_sent)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        errors += due_results.size();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: presents requests from the backlog; a presented request holds
    // until accepted. Prediction happens at the acceptance edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            live_taken = i_valid && !o_stall;
            if (live_taken) begin
                due_results.push_back(queue_outcome(live_request));
                requests_sent <= requests_sent + 1;
                if ((requests_sent % 100) == 99)
                    quiet_send <= ($urandom_range(0, 3) == 0);
            end
            if (!i_valid || live_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (request_backlog.size() > 0
                             && (!request_backlog[0].hold
                                 || (!live_taken && requests_sent == results_taken))) begin
                    live_request  = request_backlog.pop_front();
                    i_cmd        <= live_request.cmd;
                    i_route_in   <= live_request.item.route;
                    i_depart_in  <= live_request.item.depart;
                    i_arrival_in <= live_request.item.arrival;
                    i_position   <= live_request.position;
                    i_valid      <= 1'b1;
                    send_gap     <= idle_len(quiet_send);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stalls on the result side, checks each accepted result
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [TICK_W-1:0] want,
                               logic [TICK_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on result %0d, %s: expected %0h, got %0h",
                         results_taken, name, want, got);
        end
    endtask

    t_queue_result want_result;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d arrived with nothing outstanding",
                                 results_taken);
                end else begin
                    want_result = due_results.pop_front();
                    check_field("status", TICK_W'(want_result.status),
                                TICK_W'(o_status));
                    check_field("entry_count", TICK_W'(want_result.count),
                                TICK_W'(o_entry_count));
                    check_field("head_valid", TICK_W'(want_result.head_valid),
                                TICK_W'(o_head_valid));
                    check_field("head_route", TICK_W'(want_result.head.route),
                                TICK_W'(o_head_route));
                    check_field("head_depart",   want_result.head.depart,   o_head_depart);
                    check_field("head_arrival",  want_result.head.arrival,  o_head_arrival);
                    check_field("taken_route", TICK_W'(want_result.taken.route),
                                TICK_W'(o_taken_route));
                    check_field("taken_depart",  want_result.taken.depart,  o_taken_depart);
                    check_field("taken_arrival", want_result.taken.arrival, o_taken_arrival);
                end
                results_taken <= results_taken + 1;
                if ((results_taken % 100) == 99)
                    quiet_recv <= ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0) begin
                i_stall    <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= idle_len(quiet_recv);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
